// ===== sv/bsp_pkg.sv =====
// Shared types, sizes and constants of the B-spline surface point evaluator.
package bsp_pkg;

  // Grid and knot table sizes.
  localparam int PTS      = 3;
  localparam int KNOTS    = 7;
  localparam int GRID     = PTS * PTS;
  localparam int WIN      = PTS + 3;
  localparam int IDX_W    = $clog2(PTS);
  localparam int KIDX_W   = $clog2(KNOTS);
  localparam int GADDR_W  = $clog2(GRID);
  localparam int LOAD_W   = $clog2(WIN);

  // Fixed-point widths of the datapath.
  localparam int NUM_W    = 17;
  localparam int Q_W      = 18;
  localparam int N1_W     = 19;
  localparam int N_W      = 21;
  localparam int MUL_W    = 23;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int W_W      = 2 * N_W;
  localparam int ACC_W    = 60;
  localparam int PT_W     = 48;

  // Divider step count and factor clamp in Q.15.
  localparam int DIV_STEPS = 17;
  localparam logic [16:0] FACTOR_LIMIT = 17'd65536;

  // Request kinds.
  localparam logic [1:0] REQ_POINT = 2'd0;
  localparam logic [1:0] REQ_UKNOT = 2'd1;
  localparam logic [1:0] REQ_VKNOT = 2'd2;
  localparam logic [1:0] REQ_EVAL  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         slot;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [15:0]        knot_value;
    logic [15:0]        param_u;
    logic [15:0]        param_v;
  } req_t;

  typedef struct packed {
    logic signed [15:0] surf_x;
    logic signed [15:0] surf_y;
    logic signed [15:0] surf_z;
  } res_t;

  // Divider command and response.
  typedef struct packed {
    logic                     start;
    logic signed [NUM_W-1:0]  num;
    logic signed [NUM_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [Q_W-1:0]  q;
  } div_rsp_t;

endpackage

// ===== sv/bspline_surface_point_eval_core.sv =====
// Quadratic B-spline surface point evaluator: tables, basis sequencer and grid sum.
// A control point or knot write leaves the block idle, so it is ready for another request.
// An evaluate runs from acceptance to the result word through the enabled degree-one and
// degree-two blending terms (at most 28 terms), each solved by the shared bit-serial
// divider, and then through the grid sum, which visits each control point in turn.
// Reset clears the sequencer and the result valid.
module bspline_surface_point_eval_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bsp_pkg::req_t  req,
  output logic           res_valid,
  input  logic           res_stall,
  output bsp_pkg::res_t  res
);
  import bsp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_TERM, S_DIVW, S_MULW, S_G0, S_G1, S_G2, S_G3, S_OUT
  } state_t;

  state_t state;

  logic [15:0] uknot [KNOTS];
  logic [15:0] vknot [KNOTS];
  logic [15:0] kw [WIN];
  logic [15:0] tu;
  logic [15:0] tv;
  logic        dir;
  logic        pass;
  logic        side;
  logic [LOAD_W-1:0] cnt;
  logic signed [N_W-1:0]  nsum;
  logic signed [N1_W-1:0] n1 [PTS+1];
  logic signed [N_W-1:0]  nu [PTS];
  logic signed [N_W-1:0]  nv [PTS];
  logic signed [PROD_W-1:0] prod;
  logic signed [W_W-1:0]    w;
  logic [IDX_W-1:0]   gi;
  logic [IDX_W-1:0]   gj;
  logic [GADDR_W-1:0] gaddr;
  logic [1:0]         comp;
  logic               half;
  logic signed [ACC_W-1:0] acc [3];

  logic        accept;
  logic        ram_we;
  logic [PT_W-1:0] ram_rdata;
  logic [KIDX_W-1:0] kidx;
  logic [15:0] knot_rd;
  logic [15:0] t;
  logic        n0a;
  logic        n0b;
  logic        term_en;
  logic signed [NUM_W-1:0] t_num;
  logic signed [NUM_W-1:0] t_den;
  logic signed [N1_W-1:0]  n1_tap;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_bias;
  logic signed [N_W-1:0]   mul_term;
  logic        term_done;
  logic signed [N_W-1:0]   term_val;
  logic signed [N_W-1:0]   term_sum;
  logic signed [15:0]      pt_c;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_add;
  res_t        res_sat;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign ram_we    = accept && (req.req_type == REQ_POINT) && (req.slot < 4'(GRID));

  // Control point grid storage.
  bsp_ram #(.WIDTH(PT_W), .DEPTH(GRID)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.slot[GADDR_W-1:0]),
    .wdata ({req.point_x, req.point_y, req.point_z}),
    .raddr (gaddr),
    .rdata (ram_rdata)
  );

  // Knot fetch for the window load; indices past the table read the last knot.
  always_comb begin
    kidx    = (32'(cnt) >= KNOTS) ? KIDX_W'(KNOTS - 1) : KIDX_W'(cnt);
    knot_rd = dir ? vknot[kidx] : uknot[kidx];
    t       = dir ? tv : tu;
  end

  // Blending factor operands from the knot window taps.
  always_comb begin
    n0a = (kw[0] <= t) && (t < kw[1]);
    n0b = (kw[1] <= t) && (t < kw[2]);
    case ({pass, side})
      2'b00: begin
        t_num   = $signed({1'b0, t}) - $signed({1'b0, kw[0]});
        t_den   = $signed({1'b0, kw[1]}) - $signed({1'b0, kw[0]});
        n1_tap  = n1[0];
        term_en = n0a;
      end
      2'b01: begin
        t_num   = $signed({1'b0, kw[2]}) - $signed({1'b0, t});
        t_den   = $signed({1'b0, kw[2]}) - $signed({1'b0, kw[1]});
        n1_tap  = n1[1];
        term_en = n0b;
      end
      2'b10: begin
        t_num   = $signed({1'b0, t}) - $signed({1'b0, kw[0]});
        t_den   = $signed({1'b0, kw[2]}) - $signed({1'b0, kw[0]});
        n1_tap  = n1[0];
        term_en = (n1[0] != '0);
      end
      default: begin
        t_num   = $signed({1'b0, kw[3]}) - $signed({1'b0, t});
        t_den   = $signed({1'b0, kw[3]}) - $signed({1'b0, kw[1]});
        n1_tap  = n1[1];
        term_en = (n1[1] != '0);
      end
    endcase
    dreq.start = (state == S_TERM) && term_en && (t_den != '0);
    dreq.num   = t_num;
    dreq.den   = t_den;
  end

  bsp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp)
  );

  // Control point component for the grid multiply.
  always_comb begin
    case (comp)
      2'd0:    pt_c = ram_rdata[47:32];
      2'd1:    pt_c = ram_rdata[31:16];
      default: pt_c = ram_rdata[15:0];
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DIVW: begin
        mul_a = MUL_W'(drsp.q);
        mul_b = MUL_W'(n1_tap);
      end
      S_G0: begin
        mul_a = MUL_W'(nu[gi]);
        mul_b = MUL_W'(nv[gj]);
      end
      S_G2: begin
        mul_a = MUL_W'(pt_c);
        mul_b = half ? MUL_W'($signed(w[W_W-1:21])) : $signed({2'b00, w[20:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Term value and basis accumulation; products are truncated toward zero.
  always_comb begin
    prod_bias = prod + (prod[PROD_W-1] ? PROD_W'(32767) : '0);
    mul_term  = N_W'(prod_bias >>> 15);
    term_done = ((state == S_TERM) && !dreq.start) ||
                ((state == S_DIVW) && drsp.done && !pass) ||
                (state == S_MULW);
    if (state == S_TERM) begin
      term_val = '0;
    end else if (state == S_DIVW) begin
      term_val = N_W'(drsp.q);
    end else begin
      term_val = mul_term;
    end
    term_sum = nsum + term_val;
  end

  // Grid accumulation operand: low partial product, or high one shifted up.
  always_comb begin
    prod_ext = ACC_W'(prod);
    acc_add  = half ? (prod_ext <<< 21) : prod_ext;
  end

  // Output rounding toward zero and saturation.
  function automatic logic signed [15:0] sat_out(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-1:0] shifted;
    biased  = a + (a[ACC_W-1] ? ACC_W'(30'h3fffffff) : '0);
    shifted = biased >>> 30;
    if (shifted > ACC_W'(32767)) begin
      sat_out = 16'sh7fff;
    end else if (shifted < -ACC_W'(32768)) begin
      sat_out = 16'sh8000;
    end else begin
      sat_out = shifted[15:0];
    end
  endfunction

  always_comb begin
    res_sat.surf_x = sat_out(acc[0]);
    res_sat.surf_y = sat_out(acc[1]);
    res_sat.surf_z = sat_out(acc[2]);
  end

  // Knot table writes.
  always_ff @(posedge clk) begin
    if (accept && (req.slot < 4'(KNOTS))) begin
      if (req.req_type == REQ_UKNOT) begin
        uknot[req.slot[KIDX_W-1:0]] <= req.knot_value;
      end
      if (req.req_type == REQ_VKNOT) begin
        vknot[req.slot[KIDX_W-1:0]] <= req.knot_value;
      end
    end
  end

  // Shared multiplier product register.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer: window load, basis terms, grid sum and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // The finishing step reloads the output itself.
      if (res_valid && !res_stall && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (req.req_type == REQ_EVAL)) begin
            tu    <= req.param_u;
            tv    <= req.param_v;
            dir   <= 1'b0;
            pass  <= 1'b0;
            side  <= 1'b0;
            cnt   <= '0;
            nsum  <= '0;
            gi    <= '0;
            gj    <= '0;
            gaddr <= '0;
            comp  <= '0;
            half  <= 1'b0;
            for (int c = 0; c < 3; c++) begin
              acc[c] <= '0;
            end
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          kw[WIN-1] <= knot_rd;
          for (int k = 0; k < WIN - 1; k++) begin
            kw[k] <= kw[k+1];
          end
          if (cnt == LOAD_W'(WIN - 1)) begin
            cnt   <= '0;
            state <= S_TERM;
          end else begin
            cnt <= cnt + LOAD_W'(1);
          end
        end
        S_TERM: begin
          if (dreq.start) begin
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (drsp.done && pass) begin
            state <= S_MULW;
          end
        end
        S_MULW: begin
          // The finished-term step below picks the next state.
        end
        S_G0: begin
          state <= S_G1;
        end
        S_G1: begin
          w     <= prod[W_W-1:0];
          state <= S_G2;
        end
        S_G2: begin
          state <= S_G3;
        end
        S_G3: begin
          acc[comp] <= acc[comp] + acc_add;
          if (!half) begin
            half  <= 1'b1;
            state <= S_G2;
          end else begin
            half <= 1'b0;
            if (comp == 2'd2) begin
              comp <= '0;
              if (gaddr == GADDR_W'(GRID - 1)) begin
                state <= S_OUT;
              end else begin
                gaddr <= gaddr + GADDR_W'(1);
                if (gj == IDX_W'(PTS - 1)) begin
                  gj <= '0;
                  gi <= gi + IDX_W'(1);
                end else begin
                  gj <= gj + IDX_W'(1);
                end
                state <= S_G0;
              end
            end else begin
              comp  <= comp + 2'd1;
              state <= S_G2;
            end
          end
        end
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            res       <= res_sat;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Finished term: sum the two sides, store the basis value, step the window.
      if (term_done) begin
        if (!side) begin
          nsum  <= term_val;
          side  <= 1'b1;
          state <= S_TERM;
        end else begin
          nsum <= '0;
          side <= 1'b0;
          for (int k = 0; k < WIN - 1; k++) begin
            kw[k] <= kw[k+1];
          end
          for (int k = 0; k < PTS; k++) begin
            n1[k] <= n1[k+1];
          end
          if (!pass) begin
            n1[PTS] <= N1_W'(term_sum);
          end else if (!dir) begin
            nu[PTS-1] <= term_sum;
            for (int k = 0; k < PTS - 1; k++) begin
              nu[k] <= nu[k+1];
            end
          end else begin
            nv[PTS-1] <= term_sum;
            for (int k = 0; k < PTS - 1; k++) begin
              nv[k] <= nv[k+1];
            end
          end
          if (!pass && (cnt == LOAD_W'(PTS))) begin
            pass  <= 1'b1;
            cnt   <= '0;
            state <= S_LOAD;
          end else if (pass && (cnt == LOAD_W'(PTS - 1))) begin
            cnt <= '0;
            if (!dir) begin
              dir   <= 1'b1;
              pass  <= 1'b0;
              state <= S_LOAD;
            end else begin
              state <= S_G0;
            end
          end else begin
            cnt   <= cnt + LOAD_W'(1);
            state <= S_TERM;
          end
        end
      end
    end
  end

  // The divider only answers a request issued from the term step.
  assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == S_DIVW))
    else $error("divider response outside of wait step");

  // An accepted evaluate starts the knot window load.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (req.req_type == REQ_EVAL)) |=> (state == S_LOAD))
    else $error("evaluate did not start the window load");

  // A free output register always takes the finished word.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && !res_valid) |=> (res_valid && (state == S_IDLE)))
    else $error("finished word not presented");

endmodule

// ===== sv/bsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bsp_div.sv =====
// Bit-serial divider for blending factors: (num * 2^15) / den, clamped to +/-2.0.
module bsp_div (
  input  logic               clk,
  input  logic               rst,
  input  bsp_pkg::div_req_t  dreq,
  output bsp_pkg::div_rsp_t  drsp
);
  import bsp_pkg::*;

  logic        running;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [16:0] quo;
  logic [16:0] sh;
  logic        neg;

  logic [16:0] num_abs;
  logic [16:0] den_abs;
  logic        sat_hit;
  logic [16:0] rem2;
  logic        ge;
  logic [16:0] rem_diff;
  logic [16:0] quo_next;
  logic [16:0] mag;
  logic [17:0] q_final;

  // Operand magnitudes; a quotient of 2^17 or more always saturates.
  always_comb begin
    num_abs = dreq.num[16] ? (~dreq.num + 17'd1) : dreq.num;
    den_abs = dreq.den[16] ? (~dreq.den + 17'd1) : dreq.den;
    sat_hit = {1'b0, num_abs} >= {den_abs, 1'b0} + {den_abs, 1'b0};
  end

  // One restoring step per cycle.
  always_comb begin
    rem2     = {rem, sh[16]};
    ge       = rem2 >= {1'b0, dvs};
    rem_diff = rem2 - {1'b0, dvs};
    quo_next = {quo[15:0], ge};
    mag      = (quo_next > FACTOR_LIMIT) ? FACTOR_LIMIT : quo_next;
    q_final  = neg ? (~{1'b0, mag} + 18'd1) : {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      drsp.done <= 1'b0;
    end else begin
      // Done pulses after a saturated start or after the last restoring step.
      drsp.done <= dreq.start ? sat_hit : (running && (cnt == 5'(DIV_STEPS - 1)));
      if (dreq.start) begin
        neg <= dreq.num[16] ^ dreq.den[16];
        if (sat_hit) begin
          drsp.q    <= (dreq.num[16] ^ dreq.den[16]) ? (~{1'b0, FACTOR_LIMIT} + 18'd1)
                                                     : {1'b0, FACTOR_LIMIT};
        end else begin
          rem     <= {2'b00, num_abs[15:2]};
          sh      <= {num_abs[1:0], 15'd0};
          quo     <= '0;
          dvs     <= den_abs[15:0];
          cnt     <= '0;
          running <= 1'b1;
        end
      end else if (running) begin
        rem <= ge ? rem_diff[15:0] : rem2[15:0];
        sh  <= {sh[15:0], 1'b0};
        quo <= quo_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          running   <= 1'b0;
          drsp.q    <= q_final;
        end
      end
    end
  end

endmodule
